// ===== rtl/btpt_pkg.sv =====
`timescale 1ns / 1ps
package btpt_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = NODE_W + 1;
  localparam int LINK_W     = 2 * NODE_W;
  localparam int ADDR_BITS  = 32;
  localparam int LEN_W      = 6;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_START,
    ST_WALK,
    ST_LINK,
    ST_FILL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_root;
    logic rd_root;
    logic step;
    logic miss;
    logic full;
    logic link;
    logic fill;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic level_done;
    logic child_hit;
    logic is_search;
    logic pool_full;
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/binary_trie_prefix_table.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake            fields
// in        input      in_valid / in_stall  kind, prefix_address, prefix_length
// out       output     out_valid / out_stall found, status, nodes_used
//
// one transaction at a time; a lookup walks prefix_length levels, with the
// length capped at 32; the node memory read port walks one level per cycle
// each newly allocated node adds a parent link write and then a new node clear
// through the single write port, in the ST_LINK and ST_FILL states
// reset leads to ST_INIT, which clears the root entry; in_stall is high there
// the result sits in an output register, a stalled result only holds the next
// transaction in its ST_FINISH state
module binary_trie_prefix_table
  import btpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [31:0]       prefix_address,
  input  logic [LEN_W-1:0]  prefix_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              found,
  output logic              status,
  output logic [FREE_W-1:0] nodes_used
);

  cmd_t  cmd;
  stat_t stat;

  btpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  btpt_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .kind           (kind),
    .prefix_address (prefix_address),
    .prefix_length  (prefix_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .found          (found),
    .status         (status),
    .nodes_used     (nodes_used)
  );

endmodule

// ===== rtl/btpt_ctrl.sv =====
`timescale 1ns / 1ps
module btpt_ctrl
  import btpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_INIT: begin
        cmd.clear_root = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.rd_root = 1'b1;
        state_next  = ST_WALK;
      end
      ST_WALK: begin
        if (stat.level_done) begin
          state_next = ST_FINISH;
        end else if (stat.child_hit) begin
          cmd.step = 1'b1;
        end else if (stat.is_search) begin
          cmd.miss   = 1'b1;
          state_next = ST_FINISH;
        end else if (stat.pool_full) begin
          cmd.full   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_LINK;
        end
      end
      ST_LINK: begin
        cmd.link   = 1'b1;
        state_next = ST_FILL;
      end
      ST_FILL: begin
        cmd.fill   = 1'b1;
        state_next = ST_WALK;
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

// ===== rtl/btpt_dp.sv =====
`timescale 1ns / 1ps
module btpt_dp
  import btpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic              kind,
  input  logic [31:0]       prefix_address,
  input  logic [LEN_W-1:0]  prefix_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              found,
  output logic              status,
  output logic [FREE_W-1:0] nodes_used
);

  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(ADDR_BITS);
  localparam logic [FREE_W-1:0] POOL_SIZE = FREE_W'(NODE_COUNT);

  logic [LINK_W-1:0]    mem [NODE_COUNT];
  logic [LINK_W-1:0]    rd_data;
  logic                 op_kind;
  logic [ADDR_BITS-1:0] addr_sh;
  logic [LEN_W-1:0]     remaining;
  logic [NODE_W-1:0]    cur;
  logic                 fresh;
  logic [FREE_W-1:0]    next_free;
  logic                 found_flag;
  logic                 full_flag;

  logic [LINK_W-1:0]    node_data;
  logic                 dir;
  logic [NODE_W-1:0]    child;
  logic [NODE_W-1:0]    new_node;
  logic                 rd_en;
  logic [NODE_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [NODE_W-1:0]    wr_addr;
  logic [LINK_W-1:0]    wr_data;

  assign node_data = fresh ? '0 : rd_data;
  assign dir       = addr_sh[ADDR_BITS-1];
  assign child     = dir ? node_data[LINK_W-1:NODE_W] : node_data[NODE_W-1:0];
  assign new_node  = next_free[NODE_W-1:0];

  assign stat.level_done = (remaining == '0);
  assign stat.child_hit  = (child != '0);
  assign stat.is_search  = (op_kind == KIND_SEARCH);
  assign stat.pool_full  = (next_free >= POOL_SIZE);
  assign stat.out_busy   = out_valid && out_stall;

  assign rd_en   = cmd.rd_root || cmd.step;
  assign rd_addr = cmd.step ? child : '0;

  always_comb begin
    wr_en   = cmd.clear_root || cmd.link || cmd.fill;
    wr_addr = '0;
    wr_data = '0;
    if (cmd.link) begin
      wr_addr = cur;
      wr_data = dir ? {new_node, node_data[NODE_W-1:0]}
                    : {node_data[LINK_W-1:NODE_W], new_node};
    end else if (cmd.fill) begin
      wr_addr = new_node;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind   <= kind;
      addr_sh   <= prefix_address;
      remaining <= (prefix_length > LEN_MAX) ? LEN_MAX : prefix_length;
    end else if (cmd.step || cmd.fill) begin
      addr_sh   <= {addr_sh[ADDR_BITS-2:0], 1'b0};
      remaining <= remaining - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_root) begin
      cur   <= '0;
      fresh <= 1'b0;
    end else if (cmd.step) begin
      cur   <= child;
      fresh <= 1'b0;
    end else if (cmd.fill) begin
      cur   <= new_node;
      fresh <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= FREE_W'(1);
    end else if (cmd.fill) begin
      next_free <= next_free + FREE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found_flag <= (kind == KIND_SEARCH);
      full_flag  <= 1'b0;
    end else begin
      if (cmd.miss) begin
        found_flag <= 1'b0;
      end
      if (cmd.full) begin
        full_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found      <= found_flag;
      status     <= full_flag;
      nodes_used <= next_free;
    end
  end

endmodule

// ===== tb/sv/tb_binary_trie_prefix_table.sv =====
`timescale 1ns / 1ps
module tb_binary_trie_prefix_table;
  import btpt_pkg::*;

  localparam int HANG_LIMIT = 4000;
  localparam int DIRECTED_ROWS = 23;
  localparam int NOTE_DEPTH = 256;

  typedef struct packed {
    logic              found;
    logic              status;
    logic [FREE_W-1:0] nodes_used;
  } lookup_t;

  typedef struct packed {
    logic             k;
    logic [31:0]      a;
    logic [LEN_W-1:0] l;
    logic             typed;
    lookup_t          want;
  } stim_row_t;

  typedef struct {
    logic [31:0] addr;
    int          len;
  } prefix_note_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              kind;
  logic [31:0]       prefix_address;
  logic [LEN_W-1:0]  prefix_length;
  logic              out_valid;
  logic              out_stall;
  logic              found;
  logic              status;
  logic [FREE_W-1:0] nodes_used;

  int unsigned  trie_child [NODE_COUNT][2];
  int unsigned  free_node;
  lookup_t      expected_lookups [$];
  prefix_note_t inserted_prefixes [$];
  int           errors;
  int           dead_cycles;
  bit           quiet_in;
  bit           quiet_out;
  int           stall_left;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{KIND_SEARCH, 32'h0000_0000, 6'd0,  1'b1, '{1'b1, 1'b0, 13'd1}},
    '{KIND_SEARCH, 32'hFFFF_FFFF, 6'd32, 1'b1, '{1'b0, 1'b0, 13'd1}},
    '{KIND_INSERT, 32'h8000_0000, 6'd1,  1'b1, '{1'b0, 1'b0, 13'd2}},
    '{KIND_SEARCH, 32'h8000_0000, 6'd1,  1'b1, '{1'b1, 1'b0, 13'd2}},
    '{KIND_SEARCH, 32'h0000_0000, 6'd1,  1'b1, '{1'b0, 1'b0, 13'd2}},
    '{KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b1, '{1'b0, 1'b0, 13'd33}},
    '{KIND_SEARCH, 32'hFFFF_FFFF, 6'd63, 1'b1, '{1'b1, 1'b0, 13'd33}},
    '{KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b1, '{1'b0, 1'b0, 13'd33}},
    '{KIND_INSERT, 32'h0000_0000, 6'd63, 1'b1, '{1'b0, 1'b0, 13'd65}},
    '{KIND_SEARCH, 32'h0000_0000, 6'd32, 1'b1, '{1'b1, 1'b0, 13'd65}},
    '{KIND_INSERT, 32'hDEAD_BEEF, 6'd0,  1'b1, '{1'b0, 1'b0, 13'd65}},
    '{KIND_SEARCH, 32'hFFFF_0000, 6'd16, 1'b0, '{1'b0, 1'b0, 13'd0}},
    '{KIND_SEARCH, 32'hFFFF_0000, 6'd17, 1'b0, '{1'b0, 1'b0, 13'd0}},
    '{KIND_INSERT, 32'hFFFF_0000, 6'd24, 1'b0, '{1'b0, 1'b0, 13'd0}},
    '{KIND_SEARCH, 32'hFFFF_00FF, 6'd24, 1'b0, '{1'b0, 1'b0, 13'd0}},
    '{KIND_SEARCH, 32'h7FFF_FFFF, 6'd32, 1'b0, '{1'b0, 1'b0, 13'd0}},
    '{KIND_SEARCH, 32'h0000_0000, 6'd33, 1'b0, '{1'b0, 1'b0, 13'd0}},
    '{KIND_INSERT, 32'h5555_5555, 6'd40, 1'b0, '{1'b0, 1'b0, 13'd0}},
    '{KIND_SEARCH, 32'hAAAA_AAAA, 6'd32, 1'b0, '{1'b0, 1'b0, 13'd0}},
    '{KIND_SEARCH, 32'h5555_5555, 6'd32, 1'b0, '{1'b0, 1'b0, 13'd0}},
    '{KIND_INSERT, 32'h1234_5678, 6'd5,  1'b0, '{1'b0, 1'b0, 13'd0}},
    '{KIND_SEARCH, 32'h1234_5678, 6'd6,  1'b0, '{1'b0, 1'b0, 13'd0}},
    '{KIND_INSERT, 32'h0000_FFFF, 6'd20, 1'b0, '{1'b0, 1'b0, 13'd0}}
  };

  binary_trie_prefix_table i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .prefix_address (prefix_address),
    .prefix_length  (prefix_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .found          (found),
    .status         (status),
    .nodes_used     (nodes_used)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic lookup_t walk_trie(input logic k, input logic [31:0] a,
                                        input logic [LEN_W-1:0] l);
    lookup_t     r;
    int unsigned depth;
    int unsigned cur;
    int unsigned nxt;
    int unsigned b;
    int          lvl;
    r = '0;
    depth = (l > ADDR_BITS) ? ADDR_BITS : l;
    cur = 0;
    if (k == KIND_SEARCH) r.found = 1'b1;
    for (lvl = 1; lvl <= depth; lvl++) begin
      b = a[32 - lvl];
      nxt = trie_child[cur][b];
      if (nxt == 0) begin
        if (k == KIND_SEARCH) begin
          r.found = 1'b0;
          break;
        end
        if (free_node >= NODE_COUNT) begin
          r.status = 1'b1;
          break;
        end
        nxt = free_node;
        free_node++;
        trie_child[nxt][0] = 0;
        trie_child[nxt][1] = 0;
        trie_child[cur][b] = nxt;
      end
      cur = nxt;
    end
    r.nodes_used = FREE_W'(free_node);
    return r;
  endfunction

  task automatic issue_prefix(input logic k, input logic [31:0] a, input logic [LEN_W-1:0] l,
                              input logic typed, input lookup_t typed_want);
    int      gap;
    int      r;
    lookup_t got;
    if ($urandom_range(0, 39) == 0) quiet_in = !quiet_in;
    r = $urandom_range(0, 99);
    gap = 0;
    if (!quiet_in && r >= 55) gap = (r < 90) ? $urandom_range(1, 3) : $urandom_range(6, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= k;
    prefix_address <= a;
    prefix_length  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = walk_trie(k, a, l);
    expected_lookups.push_back(typed ? typed_want : got);
  endtask

  task automatic random_prefix(input bit flood);
    prefix_note_t pick;
    logic         k;
    logic [31:0]  a;
    logic [31:0]  keep;
    int           l;
    int           r;
    int           delta;
    r = $urandom_range(0, 99);
    pick = '{32'h0, 0};
    if (inserted_prefixes.size() != 0)
      pick = inserted_prefixes[$urandom_range(0, inserted_prefixes.size() - 1)];
    keep = ~(32'hFFFF_FFFF >> pick.len);
    a = $urandom;
    if (flood) begin
      k = KIND_INSERT;
      l = $urandom_range(20, 32);
    end else if (r < 30) begin
      k = KIND_SEARCH;
      delta = $urandom_range(0, 4);
      l = pick.len + delta - 2;
      if (l < 0) l = 0;
      a = (pick.addr & keep) | (a & ~keep);
    end else if (r < 45) begin
      k = KIND_SEARCH;
      l = $urandom_range(0, 63);
    end else if (r < 70) begin
      k = KIND_INSERT;
      delta = $urandom_range(0, 6);
      l = pick.len + delta;
      if (l > 63) l = 63;
      a = (pick.addr & keep) | (a & ~keep);
    end else if (r < 90) begin
      k = KIND_INSERT;
      l = $urandom_range(0, 14);
    end else begin
      k = KIND_INSERT;
      l = $urandom_range(15, 63);
    end
    issue_prefix(k, a, LEN_W'(l), 1'b0, '0);
    if (k == KIND_INSERT) begin
      if (inserted_prefixes.size() >= NOTE_DEPTH)
        inserted_prefixes.delete($urandom_range(0, NOTE_DEPTH - 1));
      inserted_prefixes.push_back('{a, l});
    end
  endtask

  // result side: check each transaction and stall at random
  always @(posedge clk) begin
    lookup_t due;
    int      r;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected result found %0b status %0b nodes_used %0d",
                 $time, found, status, nodes_used);
        errors++;
      end else begin
        due = expected_lookups.pop_front();
        if (found !== due.found) begin
          $display("%0t: found expected %0b actual %0b", $time, due.found, found);
          errors++;
        end
        if (status !== due.status) begin
          $display("%0t: status expected %0b actual %0b", $time, due.status, status);
          errors++;
        end
        if (nodes_used !== due.nodes_used) begin
          $display("%0t: nodes_used expected %0d actual %0d", $time, due.nodes_used,
                   nodes_used);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 199) == 0) quiet_out = !quiet_out;
      r = $urandom_range(0, 99);
      if (quiet_out || r < 60) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(8, 50);
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) dead_cycles <= 0;
    else dead_cycles <= dead_cycles + 1;
  end

  initial begin
    while (dead_cycles < HANG_LIMIT) @(posedge clk);
    $display("binary_trie_prefix_table: mismatch");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_INSERT;
    prefix_address = '0;
    prefix_length = '0;
    out_stall = 1'b0;
    errors = 0;
    dead_cycles = 0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    stall_left = 0;
    foreach (trie_child[n, c]) trie_child[n][c] = 0;
    free_node = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue_prefix(directed_rows[i].k, directed_rows[i].a, directed_rows[i].l,
                   directed_rows[i].typed, directed_rows[i].want);

    repeat (700) random_prefix(1'b0);

    // drain before filling the pool
    in_valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);

    while (free_node < NODE_COUNT) random_prefix(1'b1);
    repeat (280) random_prefix(1'b0);

    in_valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (110) @(posedge clk);
    if (errors == 0) $display("binary_trie_prefix_table: match");
    else $display("binary_trie_prefix_table: mismatch");
    $finish;
  end

endmodule

// ===== binary_trie_prefix_table.f =====
rtl/btpt_pkg.sv
rtl/btpt_ctrl.sv
rtl/btpt_dp.sv
rtl/binary_trie_prefix_table.sv
tb/sv/tb_binary_trie_prefix_table.sv
